>>> src/gcflt_pkg.sv
// ----------------------------------------------------------------------------
// gcflt_pkg
// Shared types and constants for the grid cell first/last timestamp recorder.
// ----------------------------------------------------------------------------
package gcflt_pkg;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MAX_Y = 3'd1;
    localparam logic [2:0] REG_WID_X = 3'd2;
    localparam logic [2:0] REG_WID_Y = 3'd3;
    localparam logic [2:0] REG_SIDE  = 3'd4;

    localparam int DIV_BITS = 33;

    // request handed from the front (divide/classify) to the back (store)
    typedef struct packed {
        logic        kind;
        logic        oor;
        logic [9:0]  addr;
        logic [4:0]  column;
        logic [4:0]  row;
        logic [31:0] stamp;
    } req_t;

    typedef struct packed {
        logic        kind;
        logic [4:0]  column;
        logic [4:0]  row;
        logic        oor;
        logic [31:0] stamp;
        logic [31:0] entry;
        logic [31:0] exit_t;
        logic [31:0] span;
        logic        visited;
    } res_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_SEND
    } front_state_t;

endpackage

>>> src/grid_cell_first_last_timestamps.sv
// ----------------------------------------------------------------------------
// grid_cell_first_last_timestamps
// Bins points into a square grid and records first/last stream time per cell.
// ----------------------------------------------------------------------------
// Path: a point's result shows after a 33-step serial divide of both axes,
//   the hand-off and the store access; a read's skips the divide.
// Flow: the front takes a new request only when idle, once it has handed the
//   last to the store; the store takes one only when no result is pending.
// Reset: rst_n clears the stream clock and the registers at once; the visited
//   bits are cleared by a pass over all 1024 cells, while requests wait.
module grid_cell_first_last_timestamps #(
    parameter int TIME_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    // request queue side
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic [9:0]         cell_index,
    // result queue side
    output logic               empty,
    input  logic               pop,
    output logic               kind,
    output logic [4:0]         column,
    output logic [4:0]         row,
    output logic               out_of_range,
    output logic [31:0]        stamp_time,
    output logic [31:0]        entry_time,
    output logic [31:0]        exit_time,
    output logic [31:0]        active_span,
    output logic               visited
);
    logic signed [31:0] min_x_reg, max_y_reg;
    logic [30:0]        wid_x_reg, wid_y_reg;
    logic [5:0]         side_reg;
    logic [5:0]         side_eff;
    logic               req_valid, req_ready;
    gcflt_pkg::req_t    req;
    gcflt_pkg::res_t    res;

    // registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            max_y_reg <= '0;
            wid_x_reg <= 31'd1;
            wid_y_reg <= 31'd1;
            side_reg  <= 6'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gcflt_pkg::REG_MIN_X: min_x_reg <= cfg_data;
                gcflt_pkg::REG_MAX_Y: max_y_reg <= cfg_data;
                gcflt_pkg::REG_WID_X: wid_x_reg <= cfg_data[30:0];
                gcflt_pkg::REG_WID_Y: wid_y_reg <= cfg_data[30:0];
                gcflt_pkg::REG_SIDE:  side_reg  <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // grid size capped at the store's side
    assign side_eff = (side_reg > 6'd32) ? 6'd32 : side_reg;

    gcflt_front #(.TIME_BITS(TIME_BITS)) u_front (
        .clk, .rst_n, .push, .full, .command, .coord_x, .coord_y, .cell_index,
        .min_x(min_x_reg), .max_y(max_y_reg), .wid_x(wid_x_reg), .wid_y(wid_y_reg),
        .side(side_eff), .req_valid, .req_ready, .req
    );

    gcflt_back u_back (
        .clk, .rst_n, .req_valid, .req_ready, .req, .empty, .pop, .res
    );

    assign kind         = res.kind;
    assign column       = res.column;
    assign row          = res.row;
    assign out_of_range = res.oor;
    assign stamp_time   = res.stamp;
    assign entry_time   = res.entry;
    assign exit_time    = res.exit_t;
    assign active_span  = res.span;
    assign visited      = res.visited;
endmodule

>>> src/gcflt_front.sv
// ----------------------------------------------------------------------------
// gcflt_front
// Accepts requests, advances the stream clock, and finds column and row with
// a bit-serial divider (both axes in parallel, one quotient bit per cycle).
// ----------------------------------------------------------------------------
module gcflt_front #(
    parameter int TIME_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 command,
    input  logic signed [31:0]   coord_x,
    input  logic signed [31:0]   coord_y,
    input  logic [9:0]           cell_index,
    input  logic signed [31:0]   min_x,
    input  logic signed [31:0]   max_y,
    input  logic [30:0]          wid_x,
    input  logic [30:0]          wid_y,
    input  logic [5:0]           side,
    output logic                 req_valid,
    input  logic                 req_ready,
    output gcflt_pkg::req_t      req
);
    localparam int CB = gcflt_pkg::DIV_BITS;

    gcflt_pkg::front_state_t state_reg, state_next;
    logic [TIME_BITS-1:0] clock_reg;
    logic [CB-1:0] qx_reg, qy_reg, rx_reg, ry_reg;
    logic [30:0]   wx_reg, wy_reg;
    logic [5:0]    cnt_reg;
    logic          kind_reg, neg_reg;
    logic [9:0]    idx_reg;
    logic [31:0]   stamp_reg;

    logic signed [32:0] dx, dy;
    logic [CB:0] trx, try_;
    logic [5:0]  n;
    logic [11:0] nn;
    logic        accept;
    logic [CB-1:0] colw, roww;

    assign n    = side;
    assign dx   = 33'(coord_x) - 33'(min_x);
    assign dy   = 33'(max_y) - 33'(coord_y);
    assign nn   = 12'(n) * 12'(n);
    assign full = (state_reg != gcflt_pkg::FS_IDLE);
    assign accept = push && !full;

    // restoring divide step
    assign trx  = {rx_reg, qx_reg[CB-1]};
    assign try_ = {ry_reg, qy_reg[CB-1]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gcflt_pkg::FS_IDLE: if (accept)
                state_next = (command == gcflt_pkg::CMD_READ) ?
                             gcflt_pkg::FS_SEND : gcflt_pkg::FS_DIV;
            gcflt_pkg::FS_DIV:  if (cnt_reg == 6'(CB - 1)) state_next = gcflt_pkg::FS_SEND;
            gcflt_pkg::FS_SEND: if (req_ready) state_next = gcflt_pkg::FS_IDLE;
            default:            state_next = gcflt_pkg::FS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gcflt_pkg::FS_IDLE;
            clock_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && command == gcflt_pkg::CMD_POINT && clock_reg != '1)
                clock_reg <= clock_reg + 1'b1;
            if (state_reg == gcflt_pkg::FS_DIV) cnt_reg <= cnt_reg + 6'd1;
            else cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= command;
            idx_reg   <= cell_index;
            neg_reg   <= dx[32] || dy[32];
            qx_reg    <= CB'(dx);
            qy_reg    <= CB'(dy);
            rx_reg    <= '0;
            ry_reg    <= '0;
            wx_reg    <= (wid_x == '0) ? 31'd1 : wid_x;
            wy_reg    <= (wid_y == '0) ? 31'd1 : wid_y;
            stamp_reg <= (clock_reg != '1) ? 32'(clock_reg + 1'b1) : 32'(clock_reg);
        end
        else if (state_reg == gcflt_pkg::FS_DIV)
        begin
            if (trx >= {3'b0, wx_reg})
            begin
                rx_reg <= CB'(trx - {3'b0, wx_reg});
                qx_reg <= {qx_reg[CB-2:0], 1'b1};
            end
            else
            begin
                rx_reg <= CB'(trx);
                qx_reg <= {qx_reg[CB-2:0], 1'b0};
            end
            if (try_ >= {3'b0, wy_reg})
            begin
                ry_reg <= CB'(try_ - {3'b0, wy_reg});
                qy_reg <= {qy_reg[CB-2:0], 1'b1};
            end
            else
            begin
                ry_reg <= CB'(try_);
                qy_reg <= {qy_reg[CB-2:0], 1'b0};
            end
        end
    end

    // read index decode: small loop over rows (n <= 32)
    logic [4:0] rd_row, rd_col;
    always_comb
    begin
        rd_row = '0;
        rd_col = '0;
        for (int r = 0; r < 32; r++)
            if (10'(r) * 10'(n) <= idx_reg && 12'(idx_reg) < nn)
            begin
                rd_row = 5'(r);
                rd_col = 5'(idx_reg - 10'(r) * 10'(n));
            end
    end

    assign colw = qx_reg;
    assign roww = qy_reg;

    always_comb
    begin
        req = '0;
        req.kind = kind_reg;
        if (kind_reg == gcflt_pkg::CMD_READ)
        begin
            req.oor = (n == 6'd0) || (12'(idx_reg) >= nn);
            if (!req.oor)
            begin
                req.addr   = idx_reg;
                req.column = rd_col;
                req.row    = rd_row;
            end
        end
        else
        begin
            req.stamp = stamp_reg;
            req.oor = neg_reg || n == 6'd0 || colw >= CB'(n) || roww >= CB'(n);
            if (!req.oor)
            begin
                req.column = 5'(colw);
                req.row    = 5'(roww);
                req.addr   = 10'(roww[4:0] * n[5:0] + 10'(colw[4:0]));
            end
        end
    end
    assign req_valid = (state_reg == gcflt_pkg::FS_SEND);
endmodule

>>> src/gcflt_back.sv
// ----------------------------------------------------------------------------
// gcflt_back
// Cell store update and read, with a one-entry result register.
// ----------------------------------------------------------------------------
module gcflt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  gcflt_pkg::req_t req,
    output logic            empty,
    input  logic            pop,
    output gcflt_pkg::res_t res
);
    logic [31:0] first_mem [1024];
    logic [31:0] last_mem  [1024];
    logic        vis_mem   [1024];
    logic          busy_reg;
    logic          full_reg;
    logic          clr_reg;
    logic [9:0]    clr_addr_reg;
    gcflt_pkg::req_t hold_reg;
    logic [31:0] f_rd, l_rd;
    logic        v_rd;
    logic        take;
    logic        upd;

    assign take      = req_valid && req_ready;
    assign req_ready = !clr_reg && !busy_reg && !full_reg;
    assign empty     = !full_reg;

    // store write in the cycle after the read, from the held request
    assign upd = busy_reg && (hold_reg.kind == gcflt_pkg::CMD_POINT) && !hold_reg.oor;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg <= req;
            f_rd <= first_mem[req.addr];
            l_rd <= last_mem[req.addr];
            v_rd <= vis_mem[req.addr];
        end
        if (upd)
        begin
            last_mem[hold_reg.addr] <= hold_reg.stamp;
            if (!v_rd) first_mem[hold_reg.addr] <= hold_reg.stamp;
        end
        // visited bits: cleared by a pass after reset, then set on a hit
        if (clr_reg) vis_mem[clr_addr_reg] <= 1'b0;
        else if (upd) vis_mem[hold_reg.addr] <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            full_reg     <= 1'b0;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            busy_reg <= take;
            if (clr_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 10'd1;
                if (clr_addr_reg == 10'd1023) clr_reg <= 1'b0;
            end
            if (busy_reg) full_reg <= 1'b1;
            else if (pop && full_reg) full_reg <= 1'b0;
        end
    end

    always_comb
    begin
        res = '0;
        res.kind   = hold_reg.kind;
        res.column = hold_reg.column;
        res.row    = hold_reg.row;
        res.oor    = hold_reg.oor;
        res.stamp  = hold_reg.stamp;
        if (hold_reg.kind == gcflt_pkg::CMD_READ && !hold_reg.oor && v_rd)
        begin
            res.entry   = f_rd;
            res.exit_t  = l_rd;
            res.span    = l_rd - f_rd;
            res.visited = 1'b1;
        end
    end
endmodule

>>> src/gcflt_checker.sv
// ----------------------------------------------------------------------------
// gcflt_checker
// Port-level checks on the result side.
// ----------------------------------------------------------------------------
module gcflt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        kind,
    input logic        out_of_range,
    input logic        visited,
    input logic [31:0] stamp_time,
    input logic [31:0] active_span,
    input logic [31:0] entry_time,
    input logic [31:0] exit_time
);
    a_ack_no_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !kind) |-> (!visited && entry_time == 32'd0))
        else $error("point ack carries cell data");
    a_read_no_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind) |-> (stamp_time == 32'd0))
        else $error("read carries a stamp");
    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind) |-> (active_span == exit_time - entry_time))
        else $error("span mismatch");
    a_bad_read: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind && out_of_range) |-> !visited)
        else $error("invalid read shows visited");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(stamp_time)
                              && $stable(out_of_range)))
        else $error("waiting result changed");
endmodule

bind grid_cell_first_last_timestamps gcflt_checker u_gcflt_checker (
    .clk, .rst_n, .empty, .pop, .kind, .out_of_range, .visited,
    .stamp_time, .active_span, .entry_time, .exit_time
);
